### rtl/pfr_pkg.sv
package pfr_pkg;

  localparam int NUM_FRAMES_DEF  = 16;
  localparam int STAMP_WIDTH_DEF = 32;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_TOUCH   = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  localparam logic [2:0] ST_FREE    = 3'd0;
  localparam logic [2:0] ST_EVICT   = 3'd1;
  localparam logic [2:0] ST_TOUCH   = 3'd2;
  localparam logic [2:0] ST_RELEASE = 3'd3;
  localparam logic [2:0] ST_REJECT  = 3'd4;

  typedef struct packed {
    logic [1:0] opcode;
    logic [3:0] frame_index;
    logic       is_write;
  } cmd_t;

  typedef struct packed {
    logic [3:0] result_frame;
    logic [2:0] status;
    logic       victim_dirty;
  } rsp_t;

endpackage

### rtl/page_frame_replacement_top.sv
// touch, release and rejected requests: result in the cycle after the request, busy stays low
// allocate with a free frame: free scan from frame 0, one frame checked per cycle, then grant
// allocate on a full pool: free scan of all frames, then clock scan of up to four passes
// over the frames or LRU scan of all frames through the stamp memory port
// one request at a time; the result strobe cannot be stalled
// synchronous reset clears frame bits, clock hand, time and policy; stamps are not cleared
module page_frame_replacement_top #(
  parameter int NUM_FRAMES  = pfr_pkg::NUM_FRAMES_DEF,
  parameter int STAMP_WIDTH = pfr_pkg::STAMP_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  pfr_pkg::cmd_t cmd,
  output logic          done,
  output pfr_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_data
);

  localparam int IDX_W = $clog2(NUM_FRAMES);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_FRAMES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FREE,
    S_CLOCK,
    S_LRU,
    S_GRANT
  } state_t;

  state_t                 state;
  logic [IDX_W-1:0]       pos;
  logic [IDX_W-1:0]       n;
  logic [1:0]             pass;
  logic [IDX_W-1:0]       victim;
  logic [IDX_W-1:0]       hand;
  logic [IDX_W-1:0]       cmp_pos;
  logic                   cmp_valid;
  logic [STAMP_WIDTH-1:0] best_stamp;
  logic [STAMP_WIDTH-1:0] ltime;
  logic                   policy;
  logic [NUM_FRAMES-1:0]  occ_bits;
  logic [NUM_FRAMES-1:0]  use_bits;
  logic [NUM_FRAMES-1:0]  dirty_bits;

  logic [STAMP_WIDTH-1:0] stamps [NUM_FRAMES];
  logic [STAMP_WIDTH-1:0] rd_data;

  logic [IDX_W+3:0]       idx_ext;
  logic [IDX_W-1:0]       idx_f;
  logic                   idx_ok;
  logic [IDX_W-1:0]       pos_wrap;
  logic [STAMP_WIDTH-1:0] ltime_next;
  logic                   clk_hit;
  logic                   lru_take;
  logic [IDX_W-1:0]       lru_victim;
  logic                   st_we;
  logic [IDX_W-1:0]       st_addr;
  logic [IDX_W+3:0]       victim_ext;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    idx_ext    = {{IDX_W{1'b0}}, cmd.frame_index};
    idx_f      = idx_ext[IDX_W-1:0];
    idx_ok     = (idx_ext < (IDX_W + 4)'(NUM_FRAMES)) && occ_bits[idx_f];
    pos_wrap   = (pos == LAST) ? '0 : pos + 1'b1;
    ltime_next = (&ltime) ? ltime : ltime + 1'b1;
    clk_hit    = !use_bits[pos] && (dirty_bits[pos] == pass[0]);
    lru_take   = (cmp_pos == '0) || (rd_data < best_stamp);
    lru_victim = lru_take ? cmp_pos : victim;
    st_we      = (state == S_GRANT) ||
                 ((state == S_IDLE) && start && (cmd.opcode == pfr_pkg::OP_TOUCH) && idx_ok);
    st_addr    = (state == S_GRANT) ? victim : idx_f;
    victim_ext = {4'b0, victim};
  end

  // stamp memory
  always_ff @(posedge clk) begin
    if (st_we) begin
      stamps[st_addr] <= ltime_next;
    end
    rd_data <= stamps[pos];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      occ_bits   <= '0;
      use_bits   <= '0;
      dirty_bits <= '0;
      hand       <= '0;
      ltime      <= '0;
      policy     <= 1'b0;
      pass       <= '0;
      n          <= '0;
      cmp_valid  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        policy <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            rsp.result_frame <= cmd.frame_index;
            rsp.victim_dirty <= 1'b0;
            rsp.status       <= pfr_pkg::ST_REJECT;
            done             <= (cmd.opcode != pfr_pkg::OP_ALLOC);
            unique case (cmd.opcode)
              pfr_pkg::OP_ALLOC: begin
                pos   <= '0;
                state <= S_FREE;
              end
              pfr_pkg::OP_TOUCH: begin
                if (idx_ok) begin
                  use_bits[idx_f] <= 1'b1;
                  if (cmd.is_write) begin
                    dirty_bits[idx_f] <= 1'b1;
                  end
                  ltime      <= ltime_next;
                  rsp.status <= pfr_pkg::ST_TOUCH;
                end
              end
              pfr_pkg::OP_RELEASE: begin
                if (idx_ok) begin
                  occ_bits[idx_f]   <= 1'b0;
                  use_bits[idx_f]   <= 1'b0;
                  dirty_bits[idx_f] <= 1'b0;
                  rsp.status        <= pfr_pkg::ST_RELEASE;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_FREE: begin
          if (!occ_bits[pos]) begin
            victim     <= pos;
            rsp.status <= pfr_pkg::ST_FREE;
            state      <= S_GRANT;
          end else if (pos == LAST) begin
            rsp.status <= pfr_pkg::ST_EVICT;
            if (policy) begin
              pos       <= '0;
              cmp_valid <= 1'b0;
              state     <= S_LRU;
            end else begin
              pos   <= hand;
              n     <= '0;
              pass  <= '0;
              state <= S_CLOCK;
            end
          end else begin
            pos <= pos_wrap;
          end
        end
        S_CLOCK: begin
          if (clk_hit) begin
            victim <= pos;
            hand   <= pos_wrap;
            state  <= S_GRANT;
          end else begin
            if (pass[0]) begin
              use_bits[pos] <= 1'b0;
            end
            pos <= pos_wrap;
            if (n == LAST) begin
              n    <= '0;
              pass <= pass + 1'b1;
            end else begin
              n <= n + 1'b1;
            end
          end
        end
        S_LRU: begin
          pos       <= pos_wrap;
          cmp_pos   <= pos;
          cmp_valid <= 1'b1;
          if (cmp_valid) begin
            if (lru_take) begin
              best_stamp <= rd_data;
            end
            victim <= lru_victim;
            if (cmp_pos == LAST) begin
              state <= S_GRANT;
            end
          end
        end
        S_GRANT: begin
          occ_bits[victim]   <= 1'b1;
          use_bits[victim]   <= 1'b1;
          dirty_bits[victim] <= 1'b0;
          ltime              <= ltime_next;
          rsp.result_frame   <= victim_ext[3:0];
          rsp.victim_dirty   <= (rsp.status == pfr_pkg::ST_EVICT) && dirty_bits[victim];
          done               <= 1'b1;
          state              <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  a_last_pass_hits: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLOCK && pass == 2'd3 && n == LAST) |-> clk_hit)
    else $error("clock scan ran out of passes");

  a_grant_bits: assert property (@(posedge clk) disable iff (rst)
    (done && (rsp.status == pfr_pkg::ST_FREE || rsp.status == pfr_pkg::ST_EVICT))
    |-> (occ_bits[victim] && use_bits[victim] && !dirty_bits[victim]))
    else $error("granted frame not set up");

  a_dirty_evict: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.victim_dirty) |-> (rsp.status == pfr_pkg::ST_EVICT))
    else $error("victim_dirty without eviction");

  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLOCK || state == S_LRU) |-> (&occ_bits))
    else $error("victim search with a free frame");

endmodule

### test/frame_policy_monitor.sv
`timescale 1ns / 100ps
module frame_policy_monitor (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          busy,
  input  pfr_pkg::cmd_t cmd,
  input  logic          done,
  input  pfr_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  input  logic          cfg_ready,
  input  logic          cfg_data,
  output int            mismatches,
  output int            outstanding,
  output int            requests_seen,
  output int            evictions_seen
);

  localparam int FRAMES = pfr_pkg::NUM_FRAMES_DEF;
  localparam int SW     = pfr_pkg::STAMP_WIDTH_DEF;

  logic [FRAMES-1:0] occupied;
  logic [FRAMES-1:0] used;
  logic [FRAMES-1:0] dirty;
  logic [SW-1:0]     stamp [FRAMES];
  logic [3:0]        hand;
  logic [SW-1:0]     now;
  logic              lru_mode;
  pfr_pkg::rsp_t     frame_results [$];

  // enhanced second chance: clean pass, dirty pass clearing use bits, repeated
  function automatic logic [3:0] clock_victim();
    logic [3:0] pos;
    for (int pass = 0; pass < 4; pass++) begin
      pos = hand;
      for (int n = 0; n < FRAMES; n++) begin
        if (!used[pos] && dirty[pos] == pass[0]) begin
          hand = pos + 4'd1;
          return pos;
        end
        if (pass[0]) begin
          used[pos] = 1'b0;
        end
        pos = pos + 4'd1;
      end
    end
    return 4'd0;
  endfunction

  // oldest stamp wins, lowest frame on a tie
  function automatic logic [3:0] lru_victim();
    logic [3:0] best;
    best = 4'd0;
    for (int i = 1; i < FRAMES; i++) begin
      if (stamp[i] < stamp[best]) begin
        best = 4'(i);
      end
    end
    return best;
  endfunction

  function automatic logic [SW-1:0] next_stamp();
    if (now != '1) begin
      now = now + 1'b1;
    end
    return now;
  endfunction

  function automatic pfr_pkg::rsp_t predict_frame_result(pfr_pkg::cmd_t c);
    pfr_pkg::rsp_t r;
    logic found;
    r.result_frame = c.frame_index;
    r.status       = pfr_pkg::ST_REJECT;
    r.victim_dirty = 1'b0;
    found          = 1'b0;
    case (c.opcode)
      pfr_pkg::OP_ALLOC: begin
        for (int i = 0; i < FRAMES; i++) begin
          if (!found && !occupied[i]) begin
            found          = 1'b1;
            r.result_frame = 4'(i);
          end
        end
        if (found) begin
          r.status = pfr_pkg::ST_FREE;
        end else begin
          if (lru_mode) begin
            r.result_frame = lru_victim();
          end else begin
            r.result_frame = clock_victim();
          end
          r.victim_dirty = dirty[r.result_frame];
          r.status       = pfr_pkg::ST_EVICT;
        end
        occupied[r.result_frame] = 1'b1;
        used[r.result_frame]     = 1'b1;
        dirty[r.result_frame]    = 1'b0;
        stamp[r.result_frame]    = next_stamp();
      end
      pfr_pkg::OP_TOUCH: begin
        if (occupied[c.frame_index]) begin
          used[c.frame_index] = 1'b1;
          if (c.is_write) begin
            dirty[c.frame_index] = 1'b1;
          end
          stamp[c.frame_index] = next_stamp();
          r.status = pfr_pkg::ST_TOUCH;
        end
      end
      pfr_pkg::OP_RELEASE: begin
        if (occupied[c.frame_index]) begin
          occupied[c.frame_index] = 1'b0;
          used[c.frame_index]     = 1'b0;
          dirty[c.frame_index]    = 1'b0;
          stamp[c.frame_index]    = '0;
          r.status = pfr_pkg::ST_RELEASE;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    pfr_pkg::rsp_t want;
    if (rst) begin
      occupied       = '0;
      used           = '0;
      dirty          = '0;
      hand           = '0;
      now            = '0;
      lru_mode       = 1'b0;
      for (int i = 0; i < FRAMES; i++) begin
        stamp[i] = '0;
      end
      frame_results.delete();
      mismatches     = 0;
      outstanding    = 0;
      requests_seen  = 0;
      evictions_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        lru_mode = cfg_data;
      end
      if (start && !busy) begin
        want = predict_frame_result(cmd);
        if (want.status == pfr_pkg::ST_EVICT) begin
          evictions_seen++;
        end
        frame_results.push_back(want);
        requests_seen++;
      end
      if (done) begin
        if (frame_results.size() == 0) begin
          $display("%0t: result with no request pending, actual frame %0d status %0d dirty %0d",
                   $time, rsp.result_frame, rsp.status, rsp.victim_dirty);
          mismatches++;
        end else begin
          want = frame_results.pop_front();
          if (rsp.result_frame !== want.result_frame) begin
            $display("%0t: result_frame mismatch, expected %0d actual %0d",
                     $time, want.result_frame, rsp.result_frame);
            mismatches++;
          end
          if (rsp.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, want.status, rsp.status);
            mismatches++;
          end
          if (rsp.victim_dirty !== want.victim_dirty) begin
            $display("%0t: victim_dirty mismatch, expected %0d actual %0d",
                     $time, want.victim_dirty, rsp.victim_dirty);
            mismatches++;
          end
        end
      end
      outstanding = frame_results.size();
    end
  end

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
module testbench;

  localparam logic [1:0] OP_UNDEF = 2'd3;

  logic          clk;
  logic          rst;
  logic          start;
  logic          busy;
  pfr_pkg::cmd_t cmd;
  logic          done;
  pfr_pkg::rsp_t rsp;
  logic          cfg_valid;
  logic          cfg_ready;
  logic          cfg_data;
  int            mismatches;
  int            outstanding;
  int            requests_seen;
  int            evictions_seen;

  page_frame_replacement_top uut (.*);
  frame_policy_monitor monitor (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic issue(input logic [1:0] op, input logic [3:0] idx, input logic wr);
    start <= 1'b1;
    cmd   <= pfr_pkg::cmd_t'{opcode: op, frame_index: idx, is_write: wr};
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic set_policy(input logic lru);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= lru;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic issue_random(input int release_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      issue(pfr_pkg::OP_ALLOC, 4'($urandom), 1'($urandom));
    end else if (roll < 40 + release_pct) begin
      issue(pfr_pkg::OP_RELEASE, 4'($urandom), 1'($urandom));
    end else if (roll < 45 + release_pct) begin
      issue(OP_UNDEF, 4'($urandom), 1'($urandom));
    end else begin
      issue(pfr_pkg::OP_TOUCH, 4'($urandom), 1'($urandom));
    end
  endtask

  task automatic run_phase(input logic lru, input int count, input int release_pct,
                           input bit bursty);
    int gap;
    int burst_left;
    set_policy(lru);
    burst_left = 0;
    for (int k = 0; k < count; k++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 29) == 0) begin
          wait_idle();
        end else if (bursty) begin
          gap = $urandom_range(0, 8);
          if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
      end
      burst_left--;
      issue_random(release_pct);
    end
  endtask

  initial begin
    #5_000_000;
    $display("timeout with %0d requests still pending", outstanding);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    cmd       = '0;
    cfg_valid = 1'b0;
    cfg_data  = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // rejects on an empty pool, then fill every frame
    set_policy(1'b0);
    issue(pfr_pkg::OP_RELEASE, 4'd0, 1'b0);
    issue(pfr_pkg::OP_TOUCH, 4'd15, 1'b1);
    issue(OP_UNDEF, 4'd15, 1'b1);
    for (int i = 0; i < 16; i++) begin
      issue(pfr_pkg::OP_ALLOC, 4'(15 - i), 1'(i));
    end
    // full pool: every use bit set, clock sweep has to clear them
    issue(pfr_pkg::OP_TOUCH, 4'd15, 1'b1);
    issue(pfr_pkg::OP_TOUCH, 4'd0, 1'b0);
    issue(pfr_pkg::OP_ALLOC, 4'd7, 1'b0);
    issue(pfr_pkg::OP_ALLOC, 4'd0, 1'b1);
    issue(pfr_pkg::OP_RELEASE, 4'd15, 1'b1);
    issue(pfr_pkg::OP_TOUCH, 4'd15, 1'b0);
    issue(pfr_pkg::OP_ALLOC, 4'd3, 1'b0);

    run_phase(1'b1, 130, 8, 1'b1);
    run_phase(1'b0, 130, 6, 1'b1);
    run_phase(1'b1, 130, 20, 1'b0);
    run_phase(1'b0, 130, 15, 1'b1);
    run_phase(1'b1, 100, 4, 1'b1);

    wait_idle();
    repeat (100) @(posedge clk);
    $display("checked %0d requests, %0d of them evictions, under clock and lru policies",
             requests_seen, evictions_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### files.f
rtl/pfr_pkg.sv
rtl/page_frame_replacement_top.sv
test/frame_policy_monitor.sv
test/testbench.sv
